// File: hdl/bgr_pkg.sv
// Package for the block group reverser: sizes, state type and size clamp.
// Depends on nothing; every other file of the block imports it.
package bgr_pkg;

    localparam int MAX_GROUP  = 16;
    localparam int ADDR_W     = $clog2(MAX_GROUP);
    localparam int CNT_W      = $clog2(MAX_GROUP + 1);
    localparam int DATA_W     = 32;
    localparam int SIZE_W     = 5;
    localparam int SIZE_RESET = 2;

    typedef enum logic {
        ST_FILL,
        ST_DRAIN
    } t_state;

    // Map the raw register to the group size in use: zero acts as one,
    // anything above the buffer depth acts as the depth.
    function automatic logic [CNT_W-1:0] f_eff_size(input logic [SIZE_W-1:0] raw);
        logic [CNT_W-1:0] k;
        if (raw == '0) begin
            k = CNT_W'(1);
        end else if (32'(raw) > MAX_GROUP) begin
            k = CNT_W'(MAX_GROUP);
        end else begin
            k = CNT_W'(raw);
        end
        return k;
    endfunction

endpackage

// File: hdl/bgr_in_if.sv
// Input channel of the block group reverser: valid, ready and one list element.
// Depends on bgr_pkg for the data width.
interface bgr_in_if;
    import bgr_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] value;
    logic                     list_last;

    modport source (output valid, output value, output list_last, input ready);
    modport sink   (input valid, input value, input list_last, output ready);
endinterface

// File: hdl/bgr_out_if.sv
// Output channel of the block group reverser: valid, ready and one result.
// Depends on bgr_pkg for the data width.
interface bgr_out_if;
    import bgr_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] out_value;
    logic                     run_last;
    logic                     list_end;

    modport source (output valid, output out_value, output run_last, output list_end,
                    input ready);
    modport sink   (input valid, input out_value, input run_last, input list_end,
                    output ready);
endinterface

// File: hdl/bgr_ram.sv
// Group buffer of the block group reverser: one write port, one read port
// with a registered, enabled read. Depends on bgr_pkg for depth and width.
module bgr_ram
    import bgr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [MAX_GROUP];
    logic [DATA_W-1:0] r_rdata;

    // Store the incoming element
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Fetch one entry; hold the last fetch while the read is idle
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/block_group_reverser.sv
// Top level of the block group reverser: fill/drain control around the group buffer.
// Depends on bgr_pkg, bgr_in_if, bgr_out_if and bgr_ram.
//
//   channel   direction  payload                          transfer when
//   i_in      in         value[31:0], list_last           valid && ready
//   o_out     out        out_value[31:0], run_last,       valid && ready
//                        list_end
//   i_cfg_*   in         i_cfg_data[4:0] (group_size)     i_cfg_we
//
// Each element is written into the buffer as it is taken. When it completes a group or
// ends the list, the block drains the n buffered elements, one buffer read per cycle
// unless o_out stalls; i_in.ready is low while draining. The output register lets the
// next element enter while the final result of a group still waits. o_out stalls hold the
// drain in place. Synchronous active-low reset empties the buffer count and sets
// group_size 2.
module block_group_reverser
    import bgr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    bgr_in_if.sink            i_in,
    bgr_out_if.source         o_out,
    input  logic              i_cfg_we,
    input  logic [SIZE_W-1:0] i_cfg_data
);

    t_state            r_state, n_state;
    logic [SIZE_W-1:0] r_group_size;
    logic [CNT_W-1:0]  r_fill, n_fill;
    logic [CNT_W-1:0]  r_n, n_n;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_rev, n_rev;
    logic              r_last, n_last;
    logic              r_out_valid, n_out_valid;
    logic              r_run_last, n_run_last;
    logic              r_list_end, n_list_end;

    logic [CNT_W-1:0]  k_eff;
    logic [CNT_W-1:0]  fill_inc;
    logic              in_xfer;
    logic              rd_en;
    logic              rd_final;
    logic [CNT_W-1:0]  rd_index;
    logic [DATA_W-1:0] rd_data;

    assign k_eff    = f_eff_size(r_group_size);
    assign fill_inc = r_fill + CNT_W'(1);
    assign in_xfer  = i_in.valid && i_in.ready;
    assign rd_final = (r_cnt == r_n - CNT_W'(1));

    // Reverse groups read from the newest entry down, partial tails from the oldest up
    assign rd_index = r_rev ? (r_n - CNT_W'(1) - r_cnt) : r_cnt;

    // Drive handshake and buffer read enable
    always_comb begin
        i_in.ready = 1'b0;
        rd_en      = 1'b0;
        case (r_state)
            ST_FILL: begin
                i_in.ready = 1'b1;
            end
            ST_DRAIN: begin
                rd_en = !r_out_valid || o_out.ready;
            end
            default: begin
                i_in.ready = 1'b0;
                rd_en      = 1'b0;
            end
        endcase
    end

    // Advance the state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_FILL: begin
                if (in_xfer && (fill_inc >= k_eff || i_in.list_last)) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (rd_en && rd_final) begin
                    n_state = ST_FILL;
                end
            end
            default: begin
                n_state = ST_FILL;
            end
        endcase
    end

    // Update fill count, drain bookkeeping and the output register
    always_comb begin
        n_fill      = r_fill;
        n_n         = r_n;
        n_cnt       = r_cnt;
        n_rev       = r_rev;
        n_last      = r_last;
        n_out_valid = r_out_valid;
        n_run_last  = r_run_last;
        n_list_end  = r_list_end;

        // Drop the result once taken; a new read below overrides this
        if (o_out.ready) begin
            n_out_valid = 1'b0;
        end

        if (in_xfer) begin
            if (fill_inc >= k_eff || i_in.list_last) begin
                n_fill = '0;
                n_n    = fill_inc;
                n_cnt  = '0;
                n_rev  = (fill_inc >= k_eff);
                n_last = i_in.list_last;
            end else begin
                n_fill = fill_inc;
            end
        end

        if (rd_en) begin
            n_cnt       = r_cnt + CNT_W'(1);
            n_out_valid = 1'b1;
            n_run_last  = rd_final;
            n_list_end  = rd_final && r_last;
        end
    end

    // Hold control state; reset clears it and sets group_size to 2
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_FILL;
            r_group_size <= SIZE_W'(SIZE_RESET);
            r_fill       <= '0;
            r_cnt        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_group_size <= i_cfg_data;
            end
        end
    end

    // Hold drain payload; no reset needed
    always_ff @(posedge i_clk) begin
        r_n        <= n_n;
        r_rev      <= n_rev;
        r_last     <= n_last;
        r_run_last <= n_run_last;
        r_list_end <= n_list_end;
    end

    bgr_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (in_xfer),
        .i_waddr (r_fill[ADDR_W-1:0]),
        .i_wdata (i_in.value),
        .i_re    (rd_en),
        .i_raddr (rd_index[ADDR_W-1:0]),
        .o_rdata (rd_data)
    );

    assign o_out.valid     = r_out_valid;
    assign o_out.out_value = $signed(rd_data);
    assign o_out.run_last  = r_run_last;
    assign o_out.list_end  = r_list_end;

    // The buffer never holds a full depth while filling
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_FILL |-> 32'(r_fill) < MAX_GROUP)
        else $error("fill count reached buffer depth while filling");

    // A drain always has an entry left to read
    a_drain_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_DRAIN |-> (r_cnt < r_n && r_n != '0))
        else $error("drain counter ran past the group length");

    // The final read of a drain returns to filling
    a_drain_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rd_en && rd_final |=> r_state == ST_FILL && r_out_valid && r_run_last)
        else $error("drain did not close with a run-last result");

    // A group starts draining with an empty fill count
    a_drain_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_FILL && n_state == ST_DRAIN |=> r_fill == '0 && r_cnt == '0)
        else $error("drain started without clearing the fill count");

endmodule

// File: verif/block_group_reverser_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for block_group_reverser: directed table, then random lists.
// Depends on bgr_pkg, bgr_in_if, bgr_out_if and the block itself.
module block_group_reverser_tb;
    import bgr_pkg::*;

    typedef struct packed {
        logic signed [DATA_W-1:0] out_value;
        logic                     run_last;
        logic                     list_end;
    } t_result;

    typedef enum {
        ROW_CFG,
        ROW_ITEM,
        ROW_ITEM_TYPED
    } t_row_kind;

    typedef struct {
        t_row_kind                kind;
        logic [SIZE_W-1:0]        size;
        logic signed [DATA_W-1:0] value;
        bit                       last;
        t_result                  want;
    } t_stim_row;

    typedef enum {
        RX_FREE,
        RX_HALF,
        RX_SPARSE
    } t_rx_mode;

    localparam int IDLE_CYCLES = 20;
    localparam int HOLD_CYCLES = 120;
    localparam int RAND_ITEMS  = 80;
    localparam logic [SIZE_W-1:0] SIZE_CHOICES [14] =
        '{5'd0, 5'd1, 5'd2, 5'd3, 5'd4, 5'd5, 5'd6, 5'd7, 5'd8, 5'd11, 5'd15, 5'd16,
          5'd17, 5'd31};

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [SIZE_W-1:0] i_cfg_data;

    bgr_in_if  in_ch ();
    bgr_out_if out_ch ();

    block_group_reverser dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // Predictor state: open group, fill level and the size register
    logic signed [DATA_W-1:0] grp_buf [MAX_GROUP];
    int unsigned              grp_fill;
    logic [SIZE_W-1:0]        size_reg;

    t_result     step_out [$];
    t_result     pending_results [$];
    t_stim_row   stim_table [$];
    int unsigned error_count;
    int unsigned burst_left;
    bit          steady;
    int unsigned hold_asks;
    int unsigned items_sent;

    // Map the raw register to the group length actually used
    function automatic int unsigned group_len(input logic [SIZE_W-1:0] raw);
        if (raw == 0) begin
            return 1;
        end
        if (int'(raw) > MAX_GROUP) begin
            return MAX_GROUP;
        end
        return int'(raw);
    endfunction

    // Store one element; on a full group or list end, emit the group
    function automatic void reverse_step(input logic signed [DATA_W-1:0] v, input bit last);
        int unsigned k;
        int unsigned n;
        t_result     res;
        k = group_len(size_reg);
        step_out.delete();
        grp_buf[grp_fill] = v;
        grp_fill++;
        n = grp_fill;
        if (n >= k) begin
            for (int unsigned i = 0; i < n; i++) begin
                res      = {grp_buf[n-1-i], i + 1 == n, (i + 1 == n) && last};
                step_out = {step_out, res};
            end
            grp_fill = 0;
        end else if (last) begin
            // partial group at list end keeps arrival order
            for (int unsigned i = 0; i < n; i++) begin
                res      = {grp_buf[i], i + 1 == n, i + 1 == n};
                step_out = {step_out, res};
            end
            grp_fill = 0;
        end
    endfunction

    function automatic void add_row(input t_row_kind kind, input logic [SIZE_W-1:0] size,
                                    input logic signed [DATA_W-1:0] value, input bit last,
                                    input t_result want);
        t_stim_row r;
        r.kind     = kind;
        r.size     = size;
        r.value    = value;
        r.last     = last;
        r.want     = want;
        stim_table = {stim_table, r};
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 11))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7FFF_FFFF;
            2:       return 32'sh0;
            3:       return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    // Insert a random gap once the current burst is used up
    task automatic pace();
        int unsigned gap;
        if (!steady) begin
            if (burst_left == 0) begin
                gap = $urandom_range(1, 6);
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
                burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                          : $urandom_range(1, 8);
            end
            burst_left--;
        end
    endtask

    // Offer one element, wait for the transfer, then record what it should produce
    task automatic send_elem(input logic signed [DATA_W-1:0] v, input bit last,
                             input bit typed, input t_result want);
        pace();
        in_ch.valid     <= 1'b1;
        in_ch.value     <= v;
        in_ch.list_last <= last;
        do @(posedge i_clk); while (!in_ch.ready);
        reverse_step(v, last);
        if (typed) begin
            pending_results = {pending_results, want};
        end else begin
            pending_results = {pending_results, step_out};
        end
    endtask

    task automatic send_list(input int unsigned len, input bit close);
        for (int unsigned i = 0; i < len; i++) begin
            send_elem(pick_value(), close && (i + 1 == len), 1'b0, '0);
            items_sent++;
        end
    endtask

    // Drop valid, wait for every outstanding result, then let the block settle
    task automatic quiesce();
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (IDLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_size(input logic [SIZE_W-1:0] s);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= s;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        size_reg = s;
    endtask

    // Compare each result transfer with the oldest expectation
    always @(posedge i_clk) begin : rx_check
        t_result want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: out_value %h run_last %0b list_end %0b",
                       out_ch.out_value, out_ch.run_last, out_ch.list_end);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (out_ch.out_value !== want.out_value) begin
                    $error("out_value: expected %h, actual %h",
                           want.out_value, out_ch.out_value);
                    error_count++;
                end
                if (out_ch.run_last !== want.run_last) begin
                    $error("run_last: expected %0b, actual %0b",
                           want.run_last, out_ch.run_last);
                    error_count++;
                end
                if (out_ch.list_end !== want.list_end) begin
                    $error("list_end: expected %0b, actual %0b",
                           want.list_end, out_ch.list_end);
                    error_count++;
                end
            end
        end
    end

    // Receiver: stall pattern in random windows, plus a long hold when the sender asks
    initial begin : rx_stall
        int unsigned win;
        int unsigned hold_left;
        int unsigned holds_taken;
        t_rx_mode    mode;
        win          = 0;
        hold_left    = 0;
        holds_taken  = 0;
        mode         = RX_FREE;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_asks != holds_taken) begin
                holds_taken++;
                hold_left = HOLD_CYCLES;
            end
            if (win == 0) begin
                case ($urandom_range(0, 3))
                    0, 1:    mode = RX_FREE;
                    2:       mode = RX_HALF;
                    default: mode = RX_SPARSE;
                endcase
                win = $urandom_range(8, 40);
            end
            win--;
            if (hold_left != 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                case (mode)
                    RX_FREE:  out_ch.ready <= 1'b1;
                    RX_HALF:  out_ch.ready <= 1'($urandom_range(0, 1));
                    default:  out_ch.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Run limit
    initial begin
        #400_000;
        $display("Verification failed");
        $finish;
    end

    // Stimulus: directed table, then random lists over several group sizes
    initial begin : stim
        int unsigned      phase;
        int unsigned      k;
        int unsigned      len;
        int unsigned      lists;
        logic [SIZE_W-1:0] new_size;

        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_data      <= '0;
        in_ch.valid     <= 1'b0;
        in_ch.value     <= '0;
        in_ch.list_last <= 1'b0;
        grp_fill    = 0;
        size_reg    = SIZE_RESET;
        error_count = 0;
        burst_left  = 0;
        steady      = 1'b0;
        hold_asks   = 0;
        items_sent  = 0;

        // after reset the size is 2: a one-element list comes straight back
        add_row(ROW_ITEM_TYPED, 5'd0, 32'sh7FFF_FFFF, 1'b1, {32'sh7FFF_FFFF, 1'b1, 1'b1});
        add_row(ROW_ITEM,       5'd0, 32'sh8000_0000, 1'b0, '0);
        add_row(ROW_ITEM,       5'd0, 32'sd1,         1'b0, '0);
        // zero size acts as pass through
        add_row(ROW_CFG,        5'd0, 32'sd0,         1'b0, '0);
        add_row(ROW_ITEM_TYPED, 5'd0, 32'sd0,         1'b0, {32'sd0, 1'b1, 1'b0});
        add_row(ROW_ITEM_TYPED, 5'd0, -32'sd1,        1'b1, {-32'sd1, 1'b1, 1'b1});
        // oversize acts as the buffer depth; list end on a partial group
        add_row(ROW_CFG,        5'd31, 32'sd0,        1'b0, '0);
        add_row(ROW_ITEM,       5'd0, 32'sh5555_5555, 1'b0, '0);
        add_row(ROW_ITEM,       5'd0, 32'shAAAA_AAAA, 1'b0, '0);
        add_row(ROW_ITEM,       5'd0, 32'sh0000_FFFF, 1'b1, '0);
        // size dropped below the fill level mid-group
        add_row(ROW_CFG,        5'd4, 32'sd0,         1'b0, '0);
        add_row(ROW_ITEM,       5'd0, 32'sd10,        1'b0, '0);
        add_row(ROW_ITEM,       5'd0, 32'sd11,        1'b0, '0);
        add_row(ROW_ITEM,       5'd0, 32'sd12,        1'b0, '0);
        add_row(ROW_CFG,        5'd2, 32'sd0,         1'b0, '0);
        add_row(ROW_ITEM,       5'd0, 32'sd13,        1'b0, '0);
        add_row(ROW_CFG,        5'd1, 32'sd0,         1'b0, '0);
        add_row(ROW_ITEM_TYPED, 5'd0, 32'sh1234_5678, 1'b0, {32'sh1234_5678, 1'b1, 1'b0});
        // list end on a full group
        add_row(ROW_CFG,        5'd3, 32'sd0,         1'b0, '0);
        add_row(ROW_ITEM,       5'd0, 32'sd1,         1'b0, '0);
        add_row(ROW_ITEM,       5'd0, 32'sd2,         1'b0, '0);
        add_row(ROW_ITEM,       5'd0, 32'sd3,         1'b1, '0);
        // largest legal size, single-element list
        add_row(ROW_CFG,        5'd16, 32'sd0,        1'b0, '0);
        add_row(ROW_ITEM_TYPED, 5'd0, -32'sd2,        1'b1, {-32'sd2, 1'b1, 1'b1});

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Walk the directed table
        foreach (stim_table[i]) begin
            case (stim_table[i].kind)
                ROW_CFG: begin
                    quiesce();
                    write_size(stim_table[i].size);
                end
                ROW_ITEM:
                    send_elem(stim_table[i].value, stim_table[i].last, 1'b0, '0);
                default:
                    send_elem(stim_table[i].value, stim_table[i].last, 1'b1,
                              stim_table[i].want);
            endcase
        end

        // Random lists; one phase per group size, the first under a long receiver hold
        phase = 0;
        while (items_sent < RAND_ITEMS) begin
            quiesce();
            case (phase)
                0:       new_size = 5'd8;
                1:       new_size = 5'd16;
                2:       new_size = 5'd31;
                default: new_size = SIZE_CHOICES[$urandom_range(0, 13)];
            endcase
            write_size(new_size);
            k = group_len(new_size);
            if (phase == 0) begin
                // back-pressure: receiver holds off while the sender keeps offering
                steady = 1'b1;
                hold_asks++;
                send_list(40, 1'b1);
                steady = 1'b0;
            end else begin
                lists = $urandom_range(1, 3);
                for (int unsigned l = 0; l < lists && items_sent < RAND_ITEMS; l++) begin
                    case ($urandom_range(0, 3))
                        0:       len = (k > 1) ? $urandom_range(1, k - 1) : 1;
                        1:       len = k * $urandom_range(1, 2);
                        2:       len = $urandom_range(1, 2 * k + 3);
                        default: len = 1;
                    endcase
                    send_list(len, 1'b1);
                    // now and then let every result drain before going on
                    if ($urandom_range(0, 3) == 0) begin
                        quiesce();
                    end
                end
                // send an unclosed run; when shorter than a group, the next size change lands mid-group
                if (items_sent < RAND_ITEMS && $urandom_range(0, 2) == 0) begin
                    send_list($urandom_range(1, k), 1'b0);
                end
            end
            phase++;
        end
        send_list(1, 1'b1);

        quiesce();
        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// File: block_group_reverser.f
hdl/bgr_pkg.sv
hdl/bgr_in_if.sv
hdl/bgr_out_if.sv
hdl/bgr_ram.sv
hdl/block_group_reverser.sv
verif/block_group_reverser_tb.sv
